/* hdl/bpl_pkg.sv */
// Shared types and constants for the bubble-pass priority list.
// Used by bpl_cell and bubble_pass_priority_list; no dependencies.
`timescale 1ns / 1ps

package bpl_pkg;

    localparam int unsigned Depth      = 16;
    localparam int unsigned HandleBits = 32;
    localparam int unsigned PrioBits   = 16;
    localparam int unsigned KindBits   = 2;
    localparam int unsigned CountBits  = $clog2(Depth + 1);
    localparam int unsigned PosBits    = $clog2(Depth);

    // input beat kinds; code 3 is a no-op
    typedef enum logic [KindBits-1:0] {
        KIND_PUSH      = 2'd0,
        KIND_PUSH_PRIO = 2'd1,
        KIND_POP       = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_SHIFT_UP,    // take the entry from the head side
        CMD_SHIFT_DOWN,  // take the entry from the tail side
        CMD_SWAP         // compare-and-swap at the pass position
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        logic      sel_lo;  // this cell is the head-side half of the pair
        logic      sel_hi;  // this cell is the tail-side half of the pair
    } cell_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_PASS
    } state_t;

endpackage

/* hdl/bubble_pass_priority_list.sv */
// Top level of the bubble-pass priority list: chain of slot cells plus control.
// Depends on bpl_pkg and bpl_cell.
`timescale 1ns / 1ps

// A list of up to 16 (handle, priority) entries held in a chain of cells, head
// at cell 0. Pops, plain pushes, refused pushes and no-ops need no pass. A
// priority push into a non-empty list first shifts the whole chain towards the
// tail, then the bubble pass walks down the chain one compare-and-swap pair per
// cycle, up to the last pair of the n entries held after the insert. The result
// beat is known at acceptance and is queued at once; the next input beat is
// taken when the pass has finished and the result queue has room.
module bubble_pass_priority_list (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] handle, [47:32] priority_req
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] popped_handle, [36:32] entries_held, rest 0
    output logic [1:0]  m_tuser    // [0] popped_valid, [1] push_refused
);

    localparam int unsigned Depth  = bpl_pkg::Depth;
    localparam int unsigned HBits  = bpl_pkg::HandleBits;
    localparam int unsigned PBits  = bpl_pkg::PrioBits;
    localparam int unsigned CBits  = bpl_pkg::CountBits;
    localparam int unsigned PsBits = bpl_pkg::PosBits;
    localparam int unsigned ResBits = HBits + CBits + 2;

    bpl_pkg::state_t state_reg;
    bpl_pkg::state_t state_next;

    logic [CBits-1:0]  count_reg;
    logic [CBits-1:0]  count_next;
    logic [PsBits-1:0] pos_reg;
    logic [PsBits-1:0] pos_next;

    logic [ResBits-1:0] out_reg;
    logic [ResBits-1:0] pend_reg;
    logic               out_valid_reg;
    logic               pend_valid_reg;

    logic                     accept;
    logic                     is_push;
    logic                     is_pop;
    logic                     full;
    logic                     do_push;
    logic                     do_pop;
    logic                     refused;
    logic                     pass_last;
    logic                     out_free;
    logic [HBits-1:0]         in_handle;
    logic signed [PBits-1:0]  in_prio;
    logic signed [PBits-1:0]  head_prio;
    logic [HBits-1:0]         pop_handle;
    logic [ResBits-1:0]       res;
    bpl_pkg::cell_cmd_t       cmd;

    bpl_pkg::cell_ctrl_t      ctrl    [Depth];
    logic [HBits-1:0]         h_q     [Depth];
    logic signed [PBits-1:0]  p_q     [Depth];
    logic                     gt_q    [Depth];

    assign in_handle = s_tdata[HBits-1:0];
    assign in_prio   = s_tdata[HBits+PBits-1:HBits];

    assign s_tready = (state_reg == bpl_pkg::ST_IDLE) && !pend_valid_reg;
    assign accept   = s_tvalid && s_tready;

    assign is_push = (s_tuser == bpl_pkg::KIND_PUSH) || (s_tuser == bpl_pkg::KIND_PUSH_PRIO);
    assign is_pop  = s_tuser == bpl_pkg::KIND_POP;
    assign full    = count_reg == CBits'(Depth);
    assign do_push = is_push && !full;
    assign do_pop  = is_pop && (count_reg != '0);
    assign refused = is_push && full;

    // plain pushes enter with priority zero
    assign head_prio = (s_tuser == bpl_pkg::KIND_PUSH_PRIO) ? in_prio : '0;

    assign pop_handle = do_pop ? h_q[0] : '0;
    assign res        = {refused, do_pop, count_next, pop_handle};

    // pair (pos, pos + 1) is the last one when pos + 2 reaches the count
    assign pass_last = (CBits'(pos_reg) + CBits'(2)) >= count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (accept && do_push)
            count_next = count_reg + CBits'(1);
        else if (accept && do_pop)
            count_next = count_reg - CBits'(1);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bpl_pkg::ST_IDLE:
                if (accept && do_push && (s_tuser == bpl_pkg::KIND_PUSH_PRIO)
                    && (count_reg != '0))
                    state_next = bpl_pkg::ST_PASS;
            bpl_pkg::ST_PASS:
                if (pass_last)
                    state_next = bpl_pkg::ST_IDLE;
            default:
                state_next = bpl_pkg::ST_IDLE;
        endcase
    end

    // chain command and pass position
    always_comb
    begin
        cmd      = bpl_pkg::CMD_HOLD;
        pos_next = pos_reg;
        case (state_reg)
            bpl_pkg::ST_IDLE:
            begin
                pos_next = '0;
                if (accept && do_push)
                    cmd = bpl_pkg::CMD_SHIFT_UP;
                else if (accept && do_pop)
                    cmd = bpl_pkg::CMD_SHIFT_DOWN;
            end
            bpl_pkg::ST_PASS:
            begin
                cmd      = bpl_pkg::CMD_SWAP;
                pos_next = pos_reg + PsBits'(1);
            end
            default:
            begin
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < Depth; gi++)
        begin : g_cell
            assign ctrl[gi].cmd    = cmd;
            assign ctrl[gi].sel_lo = pos_reg == PsBits'(gi);
            assign ctrl[gi].sel_hi = (CBits'(pos_reg) + CBits'(1)) == CBits'(gi);

            if (gi == 0)
            begin : g_head
                if (Depth > 1)
                begin : g_more
                    bpl_cell u_cell (
                        .clk        (clk),
                        .ctrl       (ctrl[gi]),
                        .prev_handle(in_handle),
                        .prev_prio  (head_prio),
                        .gt_in      (1'b0),
                        .next_handle(h_q[gi+1]),
                        .next_prio  (p_q[gi+1]),
                        .gt_out     (gt_q[gi]),
                        .handle     (h_q[gi]),
                        .prio       (p_q[gi])
                    );
                end
            end
            else if (gi == Depth - 1)
            begin : g_tail
                // tail has no neighbour: it faces itself, so never swaps down
                bpl_cell u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl[gi]),
                    .prev_handle(h_q[gi-1]),
                    .prev_prio  (p_q[gi-1]),
                    .gt_in      (gt_q[gi-1]),
                    .next_handle(h_q[gi]),
                    .next_prio  (p_q[gi]),
                    .gt_out     (gt_q[gi]),
                    .handle     (h_q[gi]),
                    .prio       (p_q[gi])
                );
            end
            else
            begin : g_mid
                bpl_cell u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl[gi]),
                    .prev_handle(h_q[gi-1]),
                    .prev_prio  (p_q[gi-1]),
                    .gt_in      (gt_q[gi-1]),
                    .next_handle(h_q[gi+1]),
                    .next_prio  (p_q[gi+1]),
                    .gt_out     (gt_q[gi]),
                    .handle     (h_q[gi]),
                    .prio       (p_q[gi])
                );
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpl_pkg::ST_IDLE;
            count_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
        end
    end

    // two-deep result queue: output register plus one waiting beat
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (pend_valid_reg && out_free)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (accept)
            begin
                if (out_free)
                    out_valid_reg <= 1'b1;
                else
                    pend_valid_reg <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_valid_reg && out_free)
            out_reg <= pend_reg;
        else if (accept && out_free)
            out_reg <= res;
        if (accept && !out_free)
            pend_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(40 - HBits - CBits){1'b0}}, out_reg[HBits+CBits-1:0]};
    assign m_tuser  = out_reg[ResBits-1:HBits+CBits];

endmodule

/* hdl/bpl_cell.sv */
// One slot of the list: handle and priority, with links to both neighbours.
// Depends on bpl_pkg.
`timescale 1ns / 1ps

module bpl_cell (
    input  logic                                   clk,
    input  bpl_pkg::cell_ctrl_t                    ctrl,
    input  logic        [bpl_pkg::HandleBits-1:0]  prev_handle,
    input  logic signed [bpl_pkg::PrioBits-1:0]    prev_prio,
    input  logic                                   gt_in,
    input  logic        [bpl_pkg::HandleBits-1:0]  next_handle,
    input  logic signed [bpl_pkg::PrioBits-1:0]    next_prio,
    output logic                                   gt_out,
    output logic        [bpl_pkg::HandleBits-1:0]  handle,
    output logic signed [bpl_pkg::PrioBits-1:0]    prio
);

    logic        [bpl_pkg::HandleBits-1:0] handle_reg;
    logic        [bpl_pkg::HandleBits-1:0] handle_next;
    logic signed [bpl_pkg::PrioBits-1:0]   prio_reg;
    logic signed [bpl_pkg::PrioBits-1:0]   prio_next;

    // strictly greater: equal priorities stay put
    assign gt_out = prio_reg > next_prio;
    assign handle = handle_reg;
    assign prio   = prio_reg;

    always_comb
    begin
        handle_next = handle_reg;
        prio_next   = prio_reg;
        case (ctrl.cmd)
            bpl_pkg::CMD_SHIFT_UP:
            begin
                handle_next = prev_handle;
                prio_next   = prev_prio;
            end
            bpl_pkg::CMD_SHIFT_DOWN:
            begin
                handle_next = next_handle;
                prio_next   = next_prio;
            end
            bpl_pkg::CMD_SWAP:
            begin
                if (ctrl.sel_lo && gt_out)
                begin
                    handle_next = next_handle;
                    prio_next   = next_prio;
                end
                else if (ctrl.sel_hi && gt_in)
                begin
                    handle_next = prev_handle;
                    prio_next   = prev_prio;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        handle_reg <= handle_next;
        prio_reg   <= prio_next;
    end

endmodule
